// ===== sv/multiset_random_sample_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MULTISET_RANDOM_SAMPLE_TABLE_ASSERT_SVH
`define MULTISET_RANDOM_SAMPLE_TABLE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MRST_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MRST_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mrst_pkg;

    localparam int DEPTH     = 1024;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int RND_W     = 32;
    localparam int STEP_W    = $clog2(RND_W);
    localparam int IN_DATA_W = DATA_W + RND_W;

    typedef logic [1:0] req_t;
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_REMOVE = 2'd1;
    localparam req_t REQ_SAMPLE = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FALSE = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    localparam logic [DATA_W-1:0] NONE_VALUE = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_WR,
        S_RD_LAST,
        S_MOVE,
        S_DIV,
        S_SMP_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] rem;
    } div_res_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [DATA_W-1:0] sample;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/multiset_random_sample_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  tdata (low bit up)                 tuser
// s_*       in         item_value[31:0], random_word[31:0] req_type[1:0]
// m_*       out        sampled_value[31:0]                 status[1:0]
//
// Insert and remove scan the live entries: they are compared one per
// cycle through the single store read port.
// Sample uses the 32-step bit-serial remainder unit to pick an entry.
// Reset is asynchronous and clears the entry count; store contents are left as is.
// A finished result waits in the output register while the next request is taken.
module multiset_random_sample_table
    import mrst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // item_value, random_word
    input  logic [1:0]           s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // sampled_value
    output logic [1:0]           m_tuser    // status
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    div_res_t          div_res;
    logic              div_start;
    logic [CNT_W-1:0]  div_divisor;
    result_t           result;
    logic              res_ready;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] m_tdata_reg, m_tdata_next;
    status_t           m_tuser_reg, m_tuser_next;

    mrst_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .item_value  (s_tdata[DATA_W-1:0]),
        .div_start   (div_start),
        .div_divisor (div_divisor),
        .div_res     (div_res),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .result      (result),
        .res_ready   (res_ready)
    );

    mrst_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    mrst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[IN_DATA_W-1:DATA_W]),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_ready)
        begin
            m_tvalid_next = result.valid;
            if (result.valid)
            begin
                m_tdata_next = result.sample;
                m_tuser_next = result.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ===== sv/mrst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mrst_ram
    import mrst_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] entry_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entry_mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= entry_mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/mrst_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mrst_div
    import mrst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RND_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output div_res_t         res
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] trial;
    logic           fits;

    // One restoring remainder step per cycle, MSB first.
    assign shifted = {rem_reg, dvd_reg[RND_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            dvd_next  = {dvd_reg[RND_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(RND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg[IDX_W-1:0];

endmodule
`default_nettype wire

// ===== sv/mrst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mrst_ctrl
    import mrst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  req_t              req_type,
    input  logic [DATA_W-1:0] item_value,
    output logic              div_start,
    output logic [CNT_W-1:0]  div_divisor,
    input  div_res_t          div_res,
    output mem_req_t          mem_req,
    input  logic [DATA_W-1:0] rd_data,
    output result_t           result,
    input  logic              res_ready
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic              found_reg, found_next;
    req_t              req_reg, req_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] sample_reg, sample_next;

    logic             hit;
    logic             scan_more;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] last_idx;

    assign hit       = cmp_valid_reg && (rd_data == value_reg);
    assign scan_more = scan_reg < count_reg;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign last_idx  = count_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (req_type)
                        REQ_INSERT: state_next = full ? S_DONE : S_SCAN;
                        REQ_REMOVE: state_next = S_SCAN;
                        REQ_SAMPLE: state_next = empty ? S_DONE : S_DIV;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (req_reg == REQ_INSERT) ? S_INS_WR : S_RD_LAST;
                end
                else if (!scan_more)
                begin
                    state_next = (req_reg == REQ_INSERT) ? S_INS_WR : S_DONE;
                end
            end
            S_INS_WR:   state_next = S_DONE;
            S_RD_LAST:  state_next = S_MOVE;
            S_MOVE:     state_next = S_DONE;
            S_DIV:      state_next = div_res.done ? S_SMP_DATA : S_DIV;
            S_SMP_DATA: state_next = S_DONE;
            S_DONE:     state_next = res_ready ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = state_reg == S_IDLE;
        div_start     = (state_reg == S_IDLE) && s_tvalid && (req_type == REQ_SAMPLE)
                        && !empty;
        div_divisor   = count_reg;
        mem_req       = '0;
        result.valid  = state_reg == S_DONE;
        result.status = status_reg;
        result.sample = sample_reg;
        unique case (state_reg)
            S_SCAN:
            begin
                mem_req.re    = !hit && scan_more;
                mem_req.raddr = scan_reg[IDX_W-1:0];
            end
            S_INS_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_reg[IDX_W-1:0];
                mem_req.wdata = value_reg;
            end
            S_RD_LAST:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = last_idx[IDX_W-1:0];
            end
            S_MOVE:
            begin
                // Fill the hole with the last live entry.
                mem_req.we    = 1'b1;
                mem_req.waddr = match_reg;
                mem_req.wdata = rd_data;
            end
            S_DIV:
            begin
                mem_req.re    = div_res.done;
                mem_req.raddr = div_res.rem;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        match_next     = match_reg;
        found_next     = found_reg;
        req_next       = req_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        sample_next    = sample_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next       = req_type;
                    value_next     = item_value;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    status_next    = ST_FALSE;
                    sample_next    = NONE_VALUE;
                    if (req_type == REQ_INSERT && full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (req_type == REQ_SAMPLE && empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle; compare the previous read's data.
                if (hit)
                begin
                    found_next     = 1'b1;
                    match_next     = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                end
                else if (scan_more)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            S_INS_WR:
            begin
                count_next  = count_reg + 1'b1;
                status_next = found_reg ? ST_FALSE : ST_OK;
            end
            S_MOVE:
            begin
                count_next  = last_idx;
                status_next = ST_OK;
            end
            S_SMP_DATA:
            begin
                status_next = ST_OK;
                sample_next = rd_data;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        match_reg   <= match_next;
        req_reg     <= req_next;
        value_reg   <= value_next;
        status_reg  <= status_next;
        sample_reg  <= sample_next;
    end

endmodule
`default_nettype wire

// ===== sv/mrst_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "multiset_random_sample_table_assert.svh"
module mrst_checker
    import mrst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic [1:0]           m_tuser
);

    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // One request at a time: ready drops after every transfer.
    `MRST_ASSERT_NEXT(a_busy_after_xfer, s_xfer, !s_tready, "ready held after request transfer")

    // No result appears in the cycle right after a request transfer.
    `MRST_ASSERT_NEXT(a_no_instant_result, s_xfer, !$rose(m_tvalid), "result too early")

    // Any status other than ok carries the all-ones value.
    `MRST_ASSERT_NOW(a_none_value, m_tvalid && (m_tuser != ST_OK),
        m_tdata == NONE_VALUE, "non-ok result with a sampled value")

    // A stalled result holds.
    `MRST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind multiset_random_sample_table mrst_checker u_chk (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import mrst_pkg::*;

    localparam req_t REQ_UNUSED    = 2'd3;
    localparam int RANDOM_ITEMS    = 500;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 1100;
    localparam int MAX_REPORTS     = 40;

    localparam logic [DATA_W-1:0] EXTREMES [4] =
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] sampled;
    } answer_t;

    typedef struct packed {
        req_t              op;
        logic [DATA_W-1:0] value;
        logic [RND_W-1:0]  rnd;
        logic              fixed;
        answer_t           want;
    } table_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LIGHT} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;   // item_value, random_word
    logic [1:0]           s_tuser = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;        // sampled_value
    logic [1:0]           m_tuser;        // status

    // shadow copy of the table
    logic [DATA_W-1:0] store_model [DEPTH];
    int unsigned       live_count = 0;

    answer_t  answer_q [$];
    int       err_count = 0;
    longint   cycle_count = 0;
    int       burst_left = 0;
    bit       sender_idles = 1'b1;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_hold = 0;
    int       rx_phase = 0;

    // expected answer typed in where it is obvious; other rows use the predictor
    table_row_t directed_rows [22] = '{
        '{REQ_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, NONE_VALUE}},
        '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'h7FFF_FFFF}},
        '{REQ_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_REMOVE, 32'h1234_5678, 32'h0000_0000, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_SAMPLE, 32'h0000_0000, 32'h8000_0000, 1'b0, '{ST_OK, 32'h0}},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_FALSE, NONE_VALUE}},
        '{REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, NONE_VALUE}},
        '{REQ_SAMPLE, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, NONE_VALUE}},
        '{REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, NONE_VALUE}}
    };

    multiset_random_sample_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    // Update the shadow table with one request and return its answer.
    function automatic answer_t predict_answer(input req_t op, input logic [DATA_W-1:0] value,
                                               input logic [RND_W-1:0] rnd);
        answer_t ans;
        bit      seen;
        int      i;
        ans.status  = ST_FALSE;
        ans.sampled = NONE_VALUE;
        seen        = 1'b0;
        case (op)
            REQ_INSERT:
            begin
                if (live_count >= DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    for (i = 0; i < live_count; i++)
                        if (store_model[i] == value)
                            seen = 1'b1;
                    ans.status = seen ? ST_FALSE : ST_OK;
                    store_model[live_count] = value;
                    live_count++;
                end
            end
            REQ_REMOVE:
            begin
                for (i = 0; i < live_count; i++)
                begin
                    if (store_model[i] == value)
                    begin
                        store_model[i] = store_model[live_count - 1];
                        live_count--;
                        ans.status = ST_OK;
                        break;
                    end
                end
            end
            REQ_SAMPLE:
            begin
                if (live_count == 0)
                begin
                    ans.status = ST_EMPTY;
                end
                else
                begin
                    ans.status  = ST_OK;
                    ans.sampled = store_model[rnd % live_count];
                end
            end
            default:
                ;
        endcase
        return ans;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return EXTREMES[$urandom_range(0, 3)];
            1, 2:    return $urandom();
            default: return 32'($urandom_range(0, 7)) - 32'd4;
        endcase
    endfunction

    function automatic logic [RND_W-1:0] pick_random_word();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, live_count + 2);
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Hold the request until transferred, then record its expected answer; after a burst, may idle.
    task automatic send_request(input req_t op, input logic [DATA_W-1:0] value,
                                input logic [RND_W-1:0] rnd,
                                input bit use_fixed = 1'b0, input answer_t fixed = '0);
        answer_t predicted;
        int      gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, value};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_answer(op, value, rnd);
        answer_q.push_back(use_fixed ? fixed : predicted);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            if (sender_idles)
            begin
                gap = $urandom_range(1, 8);
                repeat (gap)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                end
            end
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // receiver: switch at random between stall patterns
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(50, 400);
        end
        else
        begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_phase % 4 == 0);
            default:   m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        rx_phase <= rx_phase + 1;
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answer_q.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d sampled %h", $time,
                             m_tuser, m_tdata);
            end
            else
            begin
                want = answer_q.pop_front();
                if (m_tuser !== want.status)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                                 want.status, m_tuser);
                end
                if (m_tdata !== want.sampled)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: sampled_value mismatch: expected %h, actual %h",
                                 $time, want.sampled, m_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int unsigned roll;
        int unsigned ins_span;
        int unsigned rem_span;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].op, directed_rows[k].value, directed_rows[k].rnd,
                         directed_rows[k].fixed, directed_rows[k].want);

        // random mix, table kept small so scans stay short
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 32 == 0)
                sender_idles = ($urandom_range(0, 3) != 0);
            ins_span = (live_count < 4) ? 60 : (live_count > 48) ? 20 : 40;
            rem_span = (live_count > 48) ? 50 : 30;
            roll = $urandom_range(0, 99);
            if (roll < ins_span)
                send_request(REQ_INSERT, pick_value(), $urandom());
            else if (roll < ins_span + rem_span)
                send_request(REQ_REMOVE, (live_count > 0 && $urandom_range(0, 1) == 1) ?
                             store_model[$urandom_range(0, live_count - 1)] : pick_value(),
                             $urandom());
            else if (roll < 95)
                send_request(REQ_SAMPLE, $urandom(), pick_random_word());
            else
                send_request(REQ_UNUSED, $urandom(), $urandom());
        end

        // sample at both ends of the table, then drain from the front
        sender_idles = 1'b1;
        send_request(REQ_SAMPLE, $urandom(), 32'h0000_0000);
        if (live_count > 0)
            send_request(REQ_SAMPLE, $urandom(), RND_W'(live_count - 1));
        send_request(REQ_SAMPLE, $urandom(), 32'hFFFF_FFFF);
        if (live_count > 0)
            send_request(REQ_REMOVE, store_model[live_count - 1], $urandom());
        send_request(REQ_REMOVE, 32'h5A5A_A5A5, $urandom());
        send_request(REQ_INSERT, 32'h7FFF_FFFF, $urandom());
        send_request(REQ_INSERT, 32'hFFFF_FFFF, $urandom());
        while (live_count > 0)
        begin
            if ($urandom_range(0, 15) == 0)
                send_request(REQ_SAMPLE, $urandom(), pick_random_word());
            else
                send_request(REQ_REMOVE, store_model[0], $urandom());
        end
        send_request(REQ_SAMPLE, $urandom(), $urandom());
        send_request(REQ_REMOVE, pick_value(), $urandom());

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
